>>> hdl/assert_macros.svh
// Assertion macros used by the deframer core.
// Each macro samples on the rising edge of clk_i and is disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a property holds at every clock edge.
`define CFD_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks that a condition implies a consequence in the same cycle.
`define CFD_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Checks that a condition implies a consequence in the next cycle.
`define CFD_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/cfd_pkg.sv
package cfd_pkg;

  typedef enum logic [5:0] {
    ST_HUNT  = 6'b000001,
    ST_LENLO = 6'b000010,
    ST_LENHI = 6'b000100,
    ST_SEQ   = 6'b001000,
    ST_HCRC  = 6'b010000,
    ST_BODY  = 6'b100000
  } step_e;

  typedef enum logic [2:0] {
    EV_CONT       = 3'd0,
    EV_GOOD       = 3'd1,
    EV_BAD_CRC    = 3'd2,
    EV_LEN_ABORT  = 3'd3,
    EV_HDR_ABORT  = 3'd4
  } frame_event_e;

  typedef enum logic [2:0] {
    REG_START_BYTE = 3'd0,
    REG_HCRC_POLY  = 3'd1,
    REG_HCRC_INIT  = 3'd2,
    REG_FCRC_POLY  = 3'd3,
    REG_FCRC_INIT  = 3'd4
  } cfg_reg_e;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  localparam logic [7:0]  StartByteRst = 8'hA5;
  localparam logic [7:0]  HcrcPolyRst  = 8'h8C;
  localparam logic [7:0]  HcrcInitRst  = 8'hFF;
  localparam logic [15:0] FcrcPolyRst  = 16'h8408;
  localparam logic [15:0] FcrcInitRst  = 16'hFFFF;

  // Frame layout.
  localparam int unsigned Overhead     = 9;
  localparam int unsigned HdrBytes     = 5;
  localparam int unsigned CmdLoPos     = 5;
  localparam int unsigned CmdHiPos     = 6;
  localparam int unsigned TrailerExtra = 4;

endpackage

>>> hdl/cfd_rx_if.sv
interface cfd_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

>>> hdl/cfd_ev_if.sv
interface cfd_ev_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic [6:0]  byte_pos;
  logic [2:0]  frame_event;
  logic [15:0] command_id;
  logic [6:0]  payload_len;

  modport source (
    output valid, output data_byte, output byte_pos, output frame_event,
    output command_id, output payload_len, input ready
  );
  modport sink (
    input valid, input data_byte, input byte_pos, input frame_event,
    input command_id, input payload_len, output ready
  );
endinterface

>>> hdl/cfd_crc_byte.sv
module cfd_crc_byte #(
  parameter int unsigned W = 16
) (
  input  logic [W-1:0] crc_i,
  input  logic [7:0]   byte_i,
  input  logic [W-1:0] poly_i,
  output logic [W-1:0] crc_o
);

  // Reflected CRC update over one byte, least significant bit first.
  always_comb begin
    logic [W-1:0] r;
    r = crc_i ^ W'(byte_i);
    for (int i = 0; i < 8; i++) begin
      if (r[0]) begin
        r = (r >> 1) ^ poly_i;
      end else begin
        r = r >> 1;
      end
    end
    crc_o = r;
  end

endmodule

>>> hdl/crc_checked_frame_deframer_core.sv
// Channel  Dir  Payload                                                 Accepted when
// rx_i     in   rx_byte                                                 valid && ready
// ev_o     out  data_byte, byte_pos, frame_event, command_id, payload_len  valid && ready
//
// One byte per cycle sustained while ev_o is ready: an input register feeds a single stage of
// CRC and parse logic that writes the result register, from which each result is offered.
// The byte-wide CRC8 and CRC16 updates between those registers set the cycle time.
// Reset returns the parser to hunting and loads the register defaults; there is no clearing pass.
// A stalled result holds the input register, which then stalls rx_i once it holds an item.
`include "assert_macros.svh"

module crc_checked_frame_deframer_core #(
  parameter int unsigned FRAME_MAX_BYTES = 128
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [cfd_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [cfd_pkg::CfgDataW-1:0]  cfg_data_i,
  cfd_rx_if.sink                        rx_i,
  cfd_ev_if.source                      ev_o
);
  import cfd_pkg::*;

  localparam int unsigned CntW     = $clog2(FRAME_MAX_BYTES);
  localparam int unsigned PosExtW  = (CntW > 7) ? CntW : 7;
  localparam logic [15:0] LenLimit = 16'(FRAME_MAX_BYTES - Overhead);

  logic [7:0]  start_byte_q, hcrc_poly_q, hcrc_init_q;
  logic [15:0] fcrc_poly_q, fcrc_init_q;

  logic        in_vld_q;
  logic [7:0]  rx_q;
  logic        advance;

  step_e           step_q, step_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [CntW-1:0] len_q, len_d;
  logic [CntW-1:0] trail_q, trail_d;
  logic [7:0]      len_lo_q, len_lo_d;
  logic [15:0]     cmd_q, cmd_d;
  logic [7:0]      hcrc_q, hcrc_d, hcrc_base, hcrc_new;
  logic [15:0]     fcrc_q, fcrc_d, fcrc_base, fcrc_new;

  logic            has_res;
  frame_event_e    ev;
  logic [15:0]     len_full;
  logic [PosExtW-1:0] pos_ext;

  logic        out_vld_q;
  logic [7:0]  out_byte_q;
  logic [6:0]  out_pos_q;
  logic [2:0]  out_ev_q;
  logic [15:0] out_cmd_q;
  logic [6:0]  out_plen_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_byte_q <= StartByteRst;
      hcrc_poly_q  <= HcrcPolyRst;
      hcrc_init_q  <= HcrcInitRst;
      fcrc_poly_q  <= FcrcPolyRst;
      fcrc_init_q  <= FcrcInitRst;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_START_BYTE: start_byte_q <= cfg_data_i[7:0];
        REG_HCRC_POLY:  hcrc_poly_q  <= cfg_data_i[7:0];
        REG_HCRC_INIT:  hcrc_init_q  <= cfg_data_i[7:0];
        REG_FCRC_POLY:  fcrc_poly_q  <= cfg_data_i;
        REG_FCRC_INIT:  fcrc_init_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign advance    = in_vld_q && (!out_vld_q || ev_o.ready);
  assign rx_i.ready = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (rx_i.valid && rx_i.ready) begin
      in_vld_q <= 1'b1;
    end else if (advance) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_i.valid && rx_i.ready) begin
      rx_q <= rx_i.rx_byte;
    end
  end

  assign hcrc_base = (step_q == ST_HUNT) ? hcrc_init_q : hcrc_q;
  assign fcrc_base = (step_q == ST_HUNT) ? fcrc_init_q : fcrc_q;

  cfd_crc_byte #(.W(8)) u_hcrc (
    .crc_i  (hcrc_base),
    .byte_i (rx_q),
    .poly_i (hcrc_poly_q),
    .crc_o  (hcrc_new)
  );

  cfd_crc_byte #(.W(16)) u_fcrc (
    .crc_i  (fcrc_base),
    .byte_i (rx_q),
    .poly_i (fcrc_poly_q),
    .crc_o  (fcrc_new)
  );

  assign len_full = {rx_q, len_lo_q};

  always_comb begin
    step_d   = step_q;
    cnt_d    = cnt_q;
    len_d    = len_q;
    trail_d  = trail_q;
    len_lo_d = len_lo_q;
    cmd_d    = cmd_q;
    hcrc_d   = hcrc_q;
    fcrc_d   = fcrc_q;
    has_res  = 1'b1;
    ev       = EV_CONT;
    case (step_q)
      ST_HUNT: begin
        if (rx_q == start_byte_q) begin
          step_d = ST_LENLO;
        end else begin
          has_res = 1'b0;
        end
      end
      ST_LENLO: begin
        len_lo_d = rx_q;
        step_d   = ST_LENHI;
      end
      ST_LENHI: begin
        if (len_full < LenLimit) begin
          len_d  = CntW'(len_full);
          step_d = ST_SEQ;
        end else begin
          ev     = EV_LEN_ABORT;
          step_d = ST_HUNT;
        end
      end
      ST_SEQ: begin
        step_d = ST_HCRC;
      end
      ST_HCRC: begin
        if (hcrc_new == 8'd0) begin
          trail_d = len_q + CntW'(TrailerExtra);
          step_d  = ST_BODY;
        end else begin
          ev     = EV_HDR_ABORT;
          step_d = ST_HUNT;
        end
      end
      ST_BODY: begin
        if (cnt_q == CntW'(CmdLoPos)) begin
          cmd_d[7:0] = rx_q;
        end else if (cnt_q == CntW'(CmdHiPos)) begin
          cmd_d[15:8] = rx_q;
        end
        trail_d = trail_q - CntW'(1);
        if (trail_q == CntW'(1)) begin
          ev     = (fcrc_new == 16'd0) ? EV_GOOD : EV_BAD_CRC;
          step_d = ST_HUNT;
        end
      end
      default: begin
        has_res = 1'b0;
        step_d  = ST_HUNT;
        cnt_d   = '0;
      end
    endcase
    if (has_res) begin
      fcrc_d = fcrc_new;
      if (cnt_q < CntW'(HdrBytes)) begin
        hcrc_d = hcrc_new;
      end
      cnt_d = (step_d == ST_HUNT) ? '0 : cnt_q + CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= ST_HUNT;
      cnt_q   <= '0;
      len_q   <= '0;
      trail_q <= '0;
      hcrc_q  <= HcrcInitRst;
      fcrc_q  <= FcrcInitRst;
    end else if (advance) begin
      step_q  <= step_d;
      cnt_q   <= cnt_d;
      len_q   <= len_d;
      trail_q <= trail_d;
      hcrc_q  <= hcrc_d;
      fcrc_q  <= fcrc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      len_lo_q <= len_lo_d;
      cmd_q    <= cmd_d;
    end
  end

  assign pos_ext = PosExtW'(cnt_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance && has_res) begin
      out_vld_q <= 1'b1;
    end else if (ev_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && has_res) begin
      out_byte_q <= rx_q;
      out_pos_q  <= pos_ext[6:0];
      out_ev_q   <= ev;
      out_cmd_q  <= (ev == EV_GOOD) ? cmd_q : 16'd0;
      out_plen_q <= (cnt_q >= CntW'(2) && ev != EV_LEN_ABORT) ? len_lo_q[6:0] : 7'd0;
    end
  end

  assign ev_o.valid       = out_vld_q;
  assign ev_o.data_byte   = out_byte_q;
  assign ev_o.byte_pos    = out_pos_q;
  assign ev_o.frame_event = out_ev_q;
  assign ev_o.command_id  = out_cmd_q;
  assign ev_o.payload_len = out_plen_q;

  `CFD_ASSERT_IMP(a_hunt_count_zero, step_q == ST_HUNT, cnt_q == '0, "count not zero in hunt")
  `CFD_ASSERT_IMP(a_body_trail_live, step_q == ST_BODY, trail_q != '0, "body with none left")
  `CFD_ASSERT_NEXT(a_end_to_hunt, advance && has_res && ev != EV_CONT, step_q == ST_HUNT, "no hunt")
  `CFD_ASSERT_NEXT(a_in_hold, in_vld_q && !advance, in_vld_q && $stable(rx_q), "held item lost")

endmodule

>>> test/crc_checked_frame_deframer_core_test.sv
`timescale 1ns / 1ps

module crc_checked_frame_deframer_core_test;
  import cfd_pkg::*;

  localparam int unsigned FrameMax = 128;
  localparam int unsigned MaxPayload = FrameMax - Overhead - 1;
  localparam int unsigned EchoTarget = 1650;
  localparam int unsigned NumPhases = 8;
  localparam int unsigned SettleCycles = 4;
  localparam int unsigned SinkHoldCycles = 80;
  localparam int unsigned ReportLimit = 10;

  typedef struct packed {
    logic [7:0]   data_byte;
    logic [6:0]   byte_pos;
    frame_event_e frame_event;
    logic [15:0]  command_id;
    logic [6:0]   payload_len;
  } echo_t;

  typedef enum logic [1:0] {SRC_LIT, SRC_CHECK, SRC_BAD_CHECK} byte_src_e;
  typedef enum logic [1:0] {ROW_MODEL, ROW_FIXED, ROW_SILENT} row_mode_e;

  typedef struct {
    byte_src_e  src;
    logic [7:0] value;
    row_mode_e  mode;
    echo_t      want;
  } stim_row_t;

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_data;

  cfd_rx_if rx_bus ();
  cfd_ev_if ev_bus ();

  crc_checked_frame_deframer_core #(
    .FRAME_MAX_BYTES(FrameMax)
  ) uut (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data),
    .rx_i      (rx_bus),
    .ev_o      (ev_bus)
  );

  logic [7:0]  start_byte;
  logic [7:0]  hcrc_poly;
  logic [7:0]  hcrc_init;
  logic [15:0] fcrc_poly;
  logic [15:0] fcrc_init;

  step_e       pr_step;
  int unsigned pr_count;
  logic [15:0] pr_len;
  logic [7:0]  pr_hacc;
  logic [15:0] pr_facc;
  logic [15:0] pr_cmd;
  logic [15:0] pr_left;

  echo_t       echoes_due[$];
  int unsigned fail_count;
  int unsigned echoed;
  bit          src_calm;
  bit          sink_hold_req;
  bit          sink_held;

  function automatic logic [7:0] crc8_next(logic [7:0] acc, logic [7:0] b, logic [7:0] poly);
    logic [7:0] r;
    r = acc ^ b;
    repeat (8) r = r[0] ? ((r >> 1) ^ poly) : (r >> 1);
    return r;
  endfunction

  function automatic logic [15:0] crc16_next(logic [15:0] acc, logic [7:0] b,
                                             logic [15:0] poly);
    logic [15:0] r;
    r = acc ^ {8'h00, b};
    repeat (8) r = r[0] ? ((r >> 1) ^ poly) : (r >> 1);
    return r;
  endfunction

  function automatic bit deframe_byte(input logic [7:0] b, output echo_t r);
    int unsigned  pos;
    frame_event_e ev;
    r = '0;
    ev = EV_CONT;
    if (pr_step == ST_HUNT) begin
      if (b != start_byte) return 0;
      pr_count = 0;
      pr_len = '0;
      pr_cmd = '0;
      pr_left = '0;
      pr_hacc = hcrc_init;
      pr_facc = fcrc_init;
    end
    pos = pr_count;
    pr_facc = crc16_next(pr_facc, b, fcrc_poly);
    if (pos < HdrBytes) pr_hacc = crc8_next(pr_hacc, b, hcrc_poly);
    case (pr_step)
      ST_HUNT: pr_step = ST_LENLO;
      ST_LENLO: begin
        pr_len = {8'h00, b};
        pr_step = ST_LENHI;
      end
      ST_LENHI: begin
        pr_len[15:8] = b;
        if (pr_len < FrameMax - Overhead) begin
          pr_step = ST_SEQ;
        end else begin
          ev = EV_LEN_ABORT;
          pr_step = ST_HUNT;
        end
      end
      ST_SEQ: pr_step = ST_HCRC;
      ST_HCRC: begin
        if (pr_hacc == 8'h00) begin
          pr_left = 16'(pr_len + TrailerExtra);
          pr_step = ST_BODY;
        end else begin
          ev = EV_HDR_ABORT;
          pr_step = ST_HUNT;
        end
      end
      default: begin
        if (pos == CmdLoPos) pr_cmd[7:0] = b;
        else if (pos == CmdHiPos) pr_cmd[15:8] = b;
        pr_left = pr_left - 16'd1;
        if (pr_left == 16'd0) begin
          ev = (pr_facc == 16'h0000) ? EV_GOOD : EV_BAD_CRC;
          pr_step = ST_HUNT;
        end
      end
    endcase
    pr_count = (pr_step == ST_HUNT) ? 0 : pr_count + 1;
    r.data_byte = b;
    r.byte_pos = pos[6:0];
    r.frame_event = ev;
    r.command_id = (ev == EV_GOOD) ? pr_cmd : 16'h0000;
    r.payload_len = (pos >= 2 && ev != EV_LEN_ABORT) ? pr_len[6:0] : 7'd0;
    return 1;
  endfunction

  // A check byte that closes a CRC leaves the register at zero.
  function automatic logic [7:0] check_byte();
    return (pr_step == ST_HCRC) ? pr_hacc : pr_facc[7:0];
  endfunction

  function automatic string show(echo_t e);
    return $sformatf("byte %h pos %0d event %0d cmd %h len %0d", e.data_byte, e.byte_pos,
                     e.frame_event, e.command_id, e.payload_len);
  endfunction

  function automatic void record_fail(string msg);
    fail_count++;
    if (fail_count <= ReportLimit) $display("%s", msg);
  endfunction

  function automatic stim_row_t row(byte_src_e src, logic [7:0] b,
                                    row_mode_e mode = ROW_MODEL);
    stim_row_t s;
    s.src = src;
    s.value = b;
    s.mode = mode;
    s.want = '0;
    return s;
  endfunction

  function automatic stim_row_t fixed_row(logic [7:0] b, logic [6:0] pos, frame_event_e ev);
    stim_row_t s;
    s.src = SRC_LIT;
    s.value = b;
    s.mode = ROW_FIXED;
    s.want = '{b, pos, ev, 16'h0000, 7'd0};
    return s;
  endfunction

  function automatic int unsigned draw_gap();
    int unsigned pick;
    if (src_calm) return 0;
    pick = $urandom_range(0, 99);
    if (pick < 65) return 0;
    if (pick < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic offer(input logic [7:0] b, output bit got, output echo_t r);
    int unsigned gap;
    gap = draw_gap();
    if (gap > 0) begin
      @(negedge clk);
      rx_bus.valid = 1'b0;
      rx_bus.rx_byte = 8'($urandom);
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    rx_bus.valid = 1'b1;
    rx_bus.rx_byte = b;
    do @(posedge clk); while (!rx_bus.ready);
    got = deframe_byte(b, r);
    if (got) echoed++;
  endtask

  task automatic send(input logic [7:0] b);
    bit    got;
    echo_t r;
    offer(b, got, r);
    if (got) echoes_due.push_back(r);
  endtask

  task automatic settle();
    @(negedge clk);
    rx_bus.valid = 1'b0;
    while (echoes_due.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_idx = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      REG_START_BYTE: start_byte = val[7:0];
      REG_HCRC_POLY:  hcrc_poly = val[7:0];
      REG_HCRC_INIT:  hcrc_init = val[7:0];
      REG_FCRC_POLY:  fcrc_poly = val;
      REG_FCRC_INIT:  fcrc_init = val;
      default: ;
    endcase
  endtask

  task automatic send_frame(input bit hog);
    int unsigned kind;
    int unsigned pick;
    int unsigned cut;
    int unsigned idx;
    logic [15:0] len;
    bit          bad_hdr;
    bit          bad_fcrc;
    logic [7:0]  b;
    kind = hog ? 0 : $urandom_range(0, 99);
    src_calm = hog || ($urandom_range(0, 99) < 15);
    if (kind >= 93) begin
      repeat ($urandom_range(1, 8)) begin
        b = ($urandom_range(0, 3) == 0) ? start_byte : 8'($urandom);
        send(b);
      end
      while (pr_step != ST_HUNT) send(8'($urandom));
      src_calm = 1'b0;
      return;
    end
    pick = $urandom_range(0, 99);
    if (hog) begin
      len = 16'(MaxPayload);
    end else if (kind >= 78 && kind < 85) begin
      do len = 16'($urandom); while (len <= MaxPayload);
    end else if (pick < 88) begin
      len = 16'($urandom_range(0, 12));
    end else if (pick < 98) begin
      len = 16'($urandom_range(13, 60));
    end else begin
      len = 16'($urandom_range(61, MaxPayload));
    end
    bad_fcrc = kind >= 60 && kind < 70;
    bad_hdr = kind >= 70 && kind < 78;
    cut = (kind >= 85) ? $urandom_range(2, len + Overhead - 1) : 0;
    send(start_byte);
    idx = 1;
    while (pr_step != ST_HUNT && (cut == 0 || idx < cut)) begin
      case (pr_step)
        ST_LENLO: b = len[7:0];
        ST_LENHI: b = len[15:8];
        ST_HCRC:  b = check_byte() ^ {7'd0, bad_hdr};
        ST_BODY: begin
          if (pr_left <= 16'd2) b = check_byte() ^ {7'd0, bad_fcrc && pr_left == 16'd1};
          else b = ($urandom_range(0, 9) == 0) ? start_byte : 8'($urandom);
        end
        default: b = 8'($urandom);
      endcase
      send(b);
      idx++;
    end
    while (pr_step != ST_HUNT) send(8'($urandom));
    src_calm = 1'b0;
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10ms;
    $display("simulation failed");
    $finish;
  end

  initial begin
    int unsigned pick;
    ev_bus.ready = 1'b0;
    sink_held = 1'b0;
    forever begin
      @(negedge clk);
      if (sink_hold_req && !sink_held) begin
        sink_held = 1'b1;
        ev_bus.ready = 1'b0;
        repeat (SinkHoldCycles - 1) @(negedge clk);
      end else begin
        pick = $urandom_range(0, 99);
        ev_bus.ready = pick < 74;
        if (pick >= 72 && pick < 74) repeat ($urandom_range(20, 60)) @(negedge clk);
        else if (pick >= 97) repeat ($urandom_range(8, 40)) @(negedge clk);
        else if (pick >= 74) repeat ($urandom_range(0, 2)) @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    echo_t seen;
    echo_t want;
    if (rst_n && ev_bus.valid && ev_bus.ready) begin
      seen = '{ev_bus.data_byte, ev_bus.byte_pos, frame_event_e'(ev_bus.frame_event),
               ev_bus.command_id, ev_bus.payload_len};
      if (echoes_due.size() == 0) begin
        record_fail($sformatf("unexpected item: %s", show(seen)));
      end else begin
        want = echoes_due.pop_front();
        if (seen !== want) begin
          record_fail($sformatf("item mismatch: expected %s, got %s", show(want), show(seen)));
        end
      end
    end
  end

  initial begin
    stim_row_t  rows[$];
    logic [7:0] b;
    bit         got;
    echo_t      r;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_data = '0;
    rx_bus.valid = 1'b0;
    rx_bus.rx_byte = 8'h00;
    fail_count = 0;
    echoed = 0;
    src_calm = 1'b0;
    sink_hold_req = 1'b0;
    start_byte = StartByteRst;
    hcrc_poly = HcrcPolyRst;
    hcrc_init = HcrcInitRst;
    fcrc_poly = FcrcPolyRst;
    fcrc_init = FcrcInitRst;
    pr_step = ST_HUNT;
    pr_count = 0;
    pr_len = '0;
    pr_hacc = HcrcInitRst;
    pr_facc = FcrcInitRst;
    pr_cmd = '0;
    pr_left = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Length aborts at the top and at the first illegal value, an empty good frame,
    // a header abort at the largest legal length, and a bad-CRC frame with a start byte in its payload.
    rows = '{
      row(SRC_LIT, 8'h3C, ROW_SILENT),
      fixed_row(StartByteRst, 7'd0, EV_CONT),
      fixed_row(8'hFF, 7'd1, EV_CONT),
      fixed_row(8'hFF, 7'd2, EV_LEN_ABORT),
      fixed_row(StartByteRst, 7'd0, EV_CONT),
      fixed_row(8'h77, 7'd1, EV_CONT),
      fixed_row(8'h00, 7'd2, EV_LEN_ABORT),
      fixed_row(StartByteRst, 7'd0, EV_CONT),
      row(SRC_LIT, 8'h00),
      row(SRC_LIT, 8'h00),
      row(SRC_LIT, 8'h00),
      row(SRC_CHECK, 8'h00),
      row(SRC_LIT, 8'h34),
      row(SRC_LIT, 8'h12),
      row(SRC_CHECK, 8'h00),
      row(SRC_CHECK, 8'h00),
      fixed_row(StartByteRst, 7'd0, EV_CONT),
      row(SRC_LIT, 8'h76),
      row(SRC_LIT, 8'h00),
      row(SRC_LIT, 8'hFF),
      row(SRC_BAD_CHECK, 8'h00),
      fixed_row(StartByteRst, 7'd0, EV_CONT),
      row(SRC_LIT, 8'h01),
      row(SRC_LIT, 8'h00),
      row(SRC_LIT, 8'hFF),
      row(SRC_CHECK, 8'h00),
      row(SRC_LIT, 8'h00),
      row(SRC_LIT, 8'hFF),
      row(SRC_LIT, StartByteRst),
      row(SRC_CHECK, 8'h00),
      row(SRC_BAD_CHECK, 8'h00)
    };
    foreach (rows[i]) begin
      case (rows[i].src)
        SRC_CHECK:     b = check_byte();
        SRC_BAD_CHECK: b = check_byte() ^ 8'h01;
        default:       b = rows[i].value;
      endcase
      offer(b, got, r);
      if (rows[i].mode == ROW_FIXED) echoes_due.push_back(rows[i].want);
      else if (rows[i].mode == ROW_MODEL && got) echoes_due.push_back(r);
    end
    settle();

    for (int ph = 0; ph < NumPhases; ph++) begin
      case (ph)
        0: begin
          write_reg(REG_START_BYTE, {8'($urandom), 8'h00});
          write_reg(REG_HCRC_POLY, {8'($urandom), 8'hFF});
          write_reg(REG_HCRC_INIT, {8'($urandom), 8'h00});
          write_reg(REG_FCRC_POLY, 16'hFFFF);
          write_reg(REG_FCRC_INIT, 16'h0000);
        end
        1: begin
          write_reg(REG_START_BYTE, {8'($urandom), 8'hFF});
          write_reg(REG_HCRC_POLY, {8'($urandom), 8'h00});
          write_reg(REG_HCRC_INIT, {8'($urandom), 8'hFF});
          write_reg(REG_FCRC_POLY, 16'h0000);
          write_reg(REG_FCRC_INIT, 16'hFFFF);
        end
        2: begin
          write_reg(REG_START_BYTE, {8'($urandom), StartByteRst});
          write_reg(REG_HCRC_POLY, {8'($urandom), HcrcPolyRst});
          write_reg(REG_HCRC_INIT, {8'($urandom), HcrcInitRst});
          write_reg(REG_FCRC_POLY, FcrcPolyRst);
          write_reg(REG_FCRC_INIT, FcrcInitRst);
        end
        default: begin
          if ($urandom_range(0, 9) < 7) write_reg(REG_START_BYTE, 16'($urandom));
          if ($urandom_range(0, 9) < 7) write_reg(REG_HCRC_POLY, 16'($urandom));
          if ($urandom_range(0, 9) < 7) write_reg(REG_HCRC_INIT, 16'($urandom));
          if ($urandom_range(0, 9) < 7) write_reg(REG_FCRC_POLY, 16'($urandom));
          if ($urandom_range(0, 9) < 7) write_reg(REG_FCRC_INIT, 16'($urandom));
        end
      endcase
      write_reg(CfgIdxW'(REG_FCRC_INIT) + CfgIdxW'($urandom_range(1, 3)), 16'($urandom));
      if (ph == 0) begin
        sink_hold_req = 1'b1;
        send_frame(1'b1);
      end
      while (echoed < (ph + 1) * EchoTarget / NumPhases) send_frame(1'b0);
      settle();
    end

    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
